>>> rtl/core/ktsv_pkg.sv
package ktsv_pkg;

  localparam int MAX_BYTES  = 32;
  localparam int VEC_W      = 8 * MAX_BYTES;
  localparam int ROT_LEFT   = 3;
  localparam int KEY_OFFSET = 5;

  localparam logic [2:0] REG_KEY_WORD0 = 3'd0;
  localparam logic [2:0] REG_KEY_WORD1 = 3'd1;
  localparam logic [2:0] REG_KEY_WORD2 = 3'd2;
  localparam logic [2:0] REG_KEY_WORD3 = 3'd3;
  localparam logic [2:0] REG_AUTH_MODE = 3'd4;

  localparam logic [1:0] AUTH_STRICT     = 2'd0;
  localparam logic [1:0] AUTH_PERMISSIVE = 2'd1;
  localparam logic [1:0] AUTH_DISABLED   = 2'd2;

  localparam logic OP_SIGN   = 1'b0;
  localparam logic OP_VERIFY = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        last_byte;
    logic [63:0] expected_word0;
    logic [63:0] expected_word1;
    logic [63:0] expected_word2;
    logic [63:0] expected_word3;
  } item_t;

  typedef struct packed {
    logic [63:0] tag_word0;
    logic [63:0] tag_word1;
    logic [63:0] tag_word2;
    logic [63:0] tag_word3;
    logic        verified;
    logic        status;
    logic [31:0] signed_total;
    logic [31:0] verified_ok_total;
    logic [31:0] verified_fail_total;
    logic [31:0] skipped_total;
    logic [31:0] allowed_fail_total;
  } result_t;

  // message tag before the final pass, handed from front to back
  typedef struct packed {
    logic             operation;
    logic [VEC_W-1:0] tag_vec;
    logic [VEC_W-1:0] expected_vec;
  } job_t;

  function automatic logic [7:0] rotl3(input logic [7:0] v);
    rotl3 = {v[7-ROT_LEFT:0], v[7:8-ROT_LEFT]};
  endfunction

endpackage

>>> rtl/core/ktsv_front.sv
module ktsv_front #(
  parameter int KEY_BYTES = 32,
  parameter int TAG_BYTES = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  ktsv_pkg::item_t          item,
  input  logic [ktsv_pkg::VEC_W-1:0] key_vec,
  output logic                     push,
  output ktsv_pkg::job_t           push_job,
  input  logic                     queue_full
);

  localparam int TPW = $clog2(TAG_BYTES);
  localparam int KPW = $clog2(KEY_BYTES);
  localparam logic [KPW-1:0] KEY_START = KPW'(ktsv_pkg::KEY_OFFSET % KEY_BYTES);

  logic [7:0]     tag [TAG_BYTES];
  logic [7:0]     base [TAG_BYTES];
  logic [7:0]     tag_next [TAG_BYTES];
  logic           in_message;
  logic [TPW-1:0] tag_position;
  logic [KPW-1:0] key_position;
  logic [TPW-1:0] cur_p;
  logic [KPW-1:0] cur_k;
  logic [TPW-1:0] tag_position_next;
  logic [KPW-1:0] key_position_next;
  logic [7:0]     upd;
  logic           accept;

  assign item_stall = queue_full;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    cur_p = in_message ? tag_position : '0;
    cur_k = in_message ? key_position : KEY_START;
    for (int j = 0; j < TAG_BYTES; j++) begin
      base[j] = in_message ? tag[j] : key_vec[8*(j % KEY_BYTES) +: 8];
    end
    upd = ktsv_pkg::rotl3(base[cur_p] + item.data_byte) ^ key_vec[{cur_k, 3'b000} +: 8];
    for (int j = 0; j < TAG_BYTES; j++) begin
      tag_next[j] = (item.byte_present && cur_p == TPW'(j)) ? upd : base[j];
    end
    if (item.byte_present) begin
      tag_position_next = (cur_p == TPW'(TAG_BYTES - 1)) ? '0 : cur_p + 1'b1;
      key_position_next = (cur_k == KPW'(KEY_BYTES - 1)) ? '0 : cur_k + 1'b1;
    end else begin
      tag_position_next = cur_p;
      key_position_next = cur_k;
    end
  end

  always_comb begin
    push_job           = '0;
    push_job.operation = item.operation;
    push_job.expected_vec = {item.expected_word3, item.expected_word2,
                             item.expected_word1, item.expected_word0};
    for (int j = 0; j < TAG_BYTES; j++) begin
      push_job.tag_vec[8*j +: 8] = tag_next[j];
    end
  end

  assign push = accept && item.last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_message   <= 1'b0;
      tag_position <= '0;
      key_position <= KEY_START;
    end else if (accept) begin
      in_message   <= !item.last_byte;
      tag_position <= tag_position_next;
      key_position <= key_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < TAG_BYTES; j++) begin
        tag[j] <= tag_next[j];
      end
    end
  end

endmodule

>>> rtl/core/ktsv_queue.sv
module ktsv_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ktsv_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output ktsv_pkg::job_t head_job
);

  ktsv_pkg::job_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_job   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_job;
    end
  end

endmodule

>>> rtl/core/ktsv_back.sv
module ktsv_back #(
  parameter int KEY_BYTES = 32,
  parameter int TAG_BYTES = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  ktsv_pkg::job_t             head_job,
  output logic                       pop,
  input  logic [ktsv_pkg::VEC_W-1:0] key_vec,
  input  logic [1:0]                 auth_mode,
  output logic                       result_valid,
  input  logic                       result_stall,
  output ktsv_pkg::result_t          result
);

  localparam int VW = ktsv_pkg::VEC_W;

  logic [VW-1:0] fin_vec;
  logic [VW-1:0] cmp_mask;
  logic [7:0]    fin0;
  logic          match;
  logic          verified;
  logic          status;
  logic [31:0]   count_signed;
  logic [31:0]   count_verified_ok;
  logic [31:0]   count_verified_fail;
  logic [31:0]   count_skipped;
  logic [31:0]   count_allowed_fail;
  logic [31:0]   count_signed_next;
  logic [31:0]   count_verified_ok_next;
  logic [31:0]   count_verified_fail_next;
  logic [31:0]   count_skipped_next;
  logic [31:0]   count_allowed_fail_next;

  assign pop = head_valid && (!result_valid || !result_stall);

  // final pass; the last byte folds in the freshly updated byte 0
  always_comb begin
    fin_vec  = '0;
    cmp_mask = '0;
    fin0 = (head_job.tag_vec[7:0] + head_job.tag_vec[15:8]) ^ key_vec[7:0];
    for (int j = 0; j < TAG_BYTES - 1; j++) begin
      fin_vec[8*j +: 8] = (head_job.tag_vec[8*j +: 8] + head_job.tag_vec[8*(j+1) +: 8])
                          ^ key_vec[8*(j % KEY_BYTES) +: 8];
    end
    fin_vec[8*(TAG_BYTES-1) +: 8] = (head_job.tag_vec[8*(TAG_BYTES-1) +: 8] + fin0)
                                    ^ key_vec[8*((TAG_BYTES-1) % KEY_BYTES) +: 8];
    for (int j = 0; j < TAG_BYTES; j++) begin
      cmp_mask[8*j +: 8] = 8'hFF;
    end
    match = (((fin_vec ^ head_job.expected_vec) & cmp_mask) == '0);
  end

  always_comb begin
    verified                 = 1'b0;
    status                   = 1'b0;
    count_signed_next        = count_signed;
    count_verified_ok_next   = count_verified_ok;
    count_verified_fail_next = count_verified_fail;
    count_skipped_next       = count_skipped;
    count_allowed_fail_next  = count_allowed_fail;
    if (head_job.operation == ktsv_pkg::OP_SIGN) begin
      count_signed_next = count_signed + 32'd1;
    end else if (auth_mode == ktsv_pkg::AUTH_DISABLED) begin
      count_skipped_next = count_skipped + 32'd1;
    end else if (match) begin
      verified               = 1'b1;
      count_verified_ok_next = count_verified_ok + 32'd1;
    end else begin
      count_verified_fail_next = count_verified_fail + 32'd1;
      if (auth_mode == ktsv_pkg::AUTH_STRICT) begin
        status = 1'b1;
      end else begin
        count_allowed_fail_next = count_allowed_fail + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid        <= 1'b0;
      count_signed        <= '0;
      count_verified_ok   <= '0;
      count_verified_fail <= '0;
      count_skipped       <= '0;
      count_allowed_fail  <= '0;
    end else begin
      if (pop) begin
        result_valid        <= 1'b1;
        count_signed        <= count_signed_next;
        count_verified_ok   <= count_verified_ok_next;
        count_verified_fail <= count_verified_fail_next;
        count_skipped       <= count_skipped_next;
        count_allowed_fail  <= count_allowed_fail_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.tag_word0           <= fin_vec[63:0];
      result.tag_word1           <= fin_vec[127:64];
      result.tag_word2           <= fin_vec[191:128];
      result.tag_word3           <= fin_vec[255:192];
      result.verified            <= verified;
      result.status              <= status;
      result.signed_total        <= count_signed_next;
      result.verified_ok_total   <= count_verified_ok_next;
      result.verified_fail_total <= count_verified_fail_next;
      result.skipped_total       <= count_skipped_next;
      result.allowed_fail_total  <= count_allowed_fail_next;
    end
  end

endmodule

>>> rtl/core/keyed_tag_sign_verify.sv
// channel   signals                                      word
// item      item_valid, item_stall, item                 one message byte / end mark
// result    result_valid, result_stall, result           tag, verdict, counters
// config    cfg_valid, cfg_ready, cfg_index, cfg_data    one register write
//
// One item per cycle while item_stall is low; the front folds at most one byte into the tag store per item.
// A last word passes through the two-entry queue to the back, which finalises it into the result register.
// rst is synchronous; the tag is reloaded from the key at each message start.
// item_stall rises only while the queue is full; result_stall holds the result register.
module keyed_tag_sign_verify #(
  parameter int KEY_BYTES = 32,
  parameter int TAG_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  ktsv_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output ktsv_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data
);

  logic [63:0]                 key_word [4];
  logic [1:0]                  auth_mode;
  logic [ktsv_pkg::VEC_W-1:0]  key_vec;
  logic                        push;
  ktsv_pkg::job_t              push_job;
  logic                        queue_full;
  logic                        pop;
  logic                        head_valid;
  ktsv_pkg::job_t              head_job;

  assign cfg_ready = 1'b1;
  assign key_vec   = {key_word[3], key_word[2], key_word[1], key_word[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < 4; w++) begin
        key_word[w] <= '0;
      end
      auth_mode <= ktsv_pkg::AUTH_STRICT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ktsv_pkg::REG_KEY_WORD0: key_word[0] <= cfg_data;
        ktsv_pkg::REG_KEY_WORD1: key_word[1] <= cfg_data;
        ktsv_pkg::REG_KEY_WORD2: key_word[2] <= cfg_data;
        ktsv_pkg::REG_KEY_WORD3: key_word[3] <= cfg_data;
        ktsv_pkg::REG_AUTH_MODE: auth_mode   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  ktsv_front #(
    .KEY_BYTES(KEY_BYTES),
    .TAG_BYTES(TAG_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .key_vec   (key_vec),
    .push      (push),
    .push_job  (push_job),
    .queue_full(queue_full)
  );

  ktsv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (queue_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_job  (head_job)
  );

  ktsv_back #(
    .KEY_BYTES(KEY_BYTES),
    .TAG_BYTES(TAG_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_job    (head_job),
    .pop         (pop),
    .key_vec     (key_vec),
    .auth_mode   (auth_mode),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int NKEY = 32;
  localparam int NTAG = 32;
  localparam int LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE = 8;
  localparam int PHASE_ITEMS = 110;
  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam logic [1:0] AUTH_SPARE = 2'd3;

  typedef enum int {EXP_MATCH, EXP_FLIP, EXP_RANDOM, EXP_ZEROS, EXP_ONES} exp_kind_t;

  class tag_tracker;
    logic [63:0] key_w[4];
    logic [1:0] mode;
    logic [7:0] msg_bytes[$];
    bit open;
    logic [31:0] n_signed, n_ok, n_fail, n_skip, n_allowed;
    ktsv_pkg::result_t tags_due[$];
    int errors;
    int checked;

    function new();
      foreach (key_w[i]) key_w[i] = '0;
      mode = ktsv_pkg::AUTH_STRICT;
      open = 0;
      n_signed = '0;
      n_ok = '0;
      n_fail = '0;
      n_skip = '0;
      n_allowed = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] d);
      if (idx <= ktsv_pkg::REG_KEY_WORD3) key_w[idx[1:0]] = d;
      else if (idx == ktsv_pkg::REG_AUTH_MODE) mode = d[1:0];
    endfunction

    function logic [7:0] key_at(int unsigned i);
      int unsigned k;
      k = i % NKEY;
      return key_w[k / 8][8 * (k % 8) +: 8];
    endfunction

    // tag of a whole message under the current key
    function logic [255:0] message_tag(logic [7:0] msg[$]);
      logic [7:0] t[32];
      logic [7:0] s;
      int unsigned tp, kp;
      logic [255:0] v;
      for (int j = 0; j < 32; j++) t[j] = (j < NTAG) ? key_at(j) : 8'h00;
      tp = 0;
      kp = ktsv_pkg::KEY_OFFSET % NKEY;
      foreach (msg[i]) begin
        s = t[tp] + msg[i];
        t[tp] = {s[4:0], s[7:5]} ^ key_at(kp);
        tp = (tp + 1 >= NTAG) ? 0 : tp + 1;
        kp = (kp + 1 >= NKEY) ? 0 : kp + 1;
      end
      for (int j = 0; j < NTAG; j++) t[j] = (t[j] + t[(j + 1) % NTAG]) ^ key_at(j);
      v = '0;
      for (int j = 0; j < NTAG; j++) v[8 * j +: 8] = t[j];
      return v;
    endfunction

    function void note_item(ktsv_pkg::item_t it);
      logic [255:0] v;
      ktsv_pkg::result_t r;
      if (!open) begin
        msg_bytes.delete();
        open = 1;
      end
      if (it.byte_present) msg_bytes.push_back(it.data_byte);
      if (!it.last_byte) return;
      open = 0;
      v = message_tag(msg_bytes);
      r = '0;
      {r.tag_word3, r.tag_word2, r.tag_word1, r.tag_word0} = v;
      if (it.operation == ktsv_pkg::OP_SIGN) begin
        n_signed++;
      end else if (mode == ktsv_pkg::AUTH_DISABLED) begin
        n_skip++;
      end else if (v == {it.expected_word3, it.expected_word2,
                         it.expected_word1, it.expected_word0}) begin
        r.verified = 1'b1;
        n_ok++;
      end else begin
        n_fail++;
        if (mode == ktsv_pkg::AUTH_STRICT) r.status = 1'b1;
        else n_allowed++;
      end
      r.signed_total = n_signed;
      r.verified_ok_total = n_ok;
      r.verified_fail_total = n_fail;
      r.skipped_total = n_skip;
      r.allowed_fail_total = n_allowed;
      tags_due.push_back(r);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 50) $display("ERROR at %0t: %s", $realtime, what);
    endtask

    task cmp(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_result(ktsv_pkg::result_t got);
      ktsv_pkg::result_t want;
      if (tags_due.size() == 0) begin
        report("result word with nothing outstanding");
        return;
      end
      want = tags_due.pop_front();
      checked++;
      cmp("tag_word0", got.tag_word0, want.tag_word0);
      cmp("tag_word1", got.tag_word1, want.tag_word1);
      cmp("tag_word2", got.tag_word2, want.tag_word2);
      cmp("tag_word3", got.tag_word3, want.tag_word3);
      cmp("verified", 64'(got.verified), 64'(want.verified));
      cmp("status", 64'(got.status), 64'(want.status));
      cmp("signed_total", 64'(got.signed_total), 64'(want.signed_total));
      cmp("verified_ok_total", 64'(got.verified_ok_total), 64'(want.verified_ok_total));
      cmp("verified_fail_total", 64'(got.verified_fail_total),
          64'(want.verified_fail_total));
      cmp("skipped_total", 64'(got.skipped_total), 64'(want.skipped_total));
      cmp("allowed_fail_total", 64'(got.allowed_fail_total),
          64'(want.allowed_fail_total));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  ktsv_pkg::item_t item_word = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  ktsv_pkg::result_t result_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  tag_tracker board;
  bit calm = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;
  int cycles = 0;
  int items_sent = 0;
  int messages = 0;
  int settings = 0;

  keyed_tag_sign_verify #(.KEY_BYTES(NKEY), .TAG_BYTES(NTAG)) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item_word),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [255:0] rand_wide();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[32 * i +: 32] = $urandom;
    return v;
  endfunction

  function automatic ktsv_pkg::item_t rand_item();
    ktsv_pkg::item_t it;
    logic [255:0] e;
    e = rand_wide();
    it.operation = 1'($urandom_range(0, 1));
    it.data_byte = 8'($urandom);
    it.byte_present = 1'($urandom_range(0, 1));
    it.last_byte = 1'($urandom_range(0, 1));
    {it.expected_word3, it.expected_word2, it.expected_word1, it.expected_word0} = e;
    return it;
  endfunction

  function automatic exp_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return EXP_MATCH;
    if (r < 70) return EXP_FLIP;
    if (r < 90) return EXP_RANDOM;
    if (r < 95) return EXP_ZEROS;
    return EXP_ONES;
  endfunction

  // result side: short random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (calm) begin
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left = gap_len();
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) board.note_item(item_word);
      if (result_valid && !result_stall) board.check_result(result_word);
    end
  end

  initial begin
    while (cycles <= LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycles, board.tags_due.size());
    $display("keyed_tag_sign_verify test failed");
    $finish;
  end

  task automatic offer(ktsv_pkg::item_t it);
    int gap;
    item_valid <= 1'b1;
    item_word <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (board.tags_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.set_reg(idx, d);
    @(posedge clk);
  endtask

  task automatic load_key(logic [255:0] k);
    write_reg(ktsv_pkg::REG_KEY_WORD0, k[63:0]);
    write_reg(ktsv_pkg::REG_KEY_WORD1, k[127:64]);
    write_reg(ktsv_pkg::REG_KEY_WORD2, k[191:128]);
    write_reg(ktsv_pkg::REG_KEY_WORD3, k[255:192]);
    settings++;
  endtask

  // body bytes, optional no-byte fillers, then the closing word
  task automatic send_message(logic [7:0] msg[$], logic op, exp_kind_t kind,
                              bit carry, int noise_pct);
    ktsv_pkg::item_t it;
    logic [255:0] want;
    int body;
    want = board.message_tag(msg);
    case (kind)
      EXP_MATCH:  ;
      EXP_FLIP:   want = want ^ (256'd1 << $urandom_range(0, 255));
      EXP_RANDOM: want = rand_wide();
      EXP_ZEROS:  want = '0;
      default:    want = '1;
    endcase
    carry = carry && (msg.size() > 0);
    body = carry ? msg.size() - 1 : msg.size();
    for (int i = 0; i < body; i++) begin
      if ($urandom_range(1, 100) <= noise_pct) begin
        it = rand_item();
        it.byte_present = 1'b0;
        it.last_byte = 1'b0;
        offer(it);
      end
      it = rand_item();
      it.data_byte = msg[i];
      it.byte_present = 1'b1;
      it.last_byte = 1'b0;
      offer(it);
    end
    it = rand_item();
    it.operation = op;
    it.byte_present = carry;
    if (carry) it.data_byte = msg[msg.size() - 1];
    it.last_byte = 1'b1;
    {it.expected_word3, it.expected_word2, it.expected_word1, it.expected_word0} = want;
    offer(it);
    messages++;
  endtask

  task automatic random_message(int max_len);
    logic [7:0] msg[$];
    int r, len;
    r = $urandom_range(0, 99);
    if (r < 70) len = $urandom_range(0, 6);
    else if (r < 90) len = $urandom_range(7, 33);
    else len = $urandom_range(34, 80);
    if (len > max_len) len = max_len;
    repeat (len) msg.push_back(8'($urandom));
    send_message(msg, 1'($urandom_range(0, 1)), pick_kind(), 1'($urandom_range(0, 1)), 10);
  endtask

  initial begin
    logic [7:0] msg[$];
    logic [63:0] d;
    int start;
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_key(256'h0123456789abcdef_fedcba9876543210_a5a55a5a0ff0f00f_8000000000000001);
    write_reg(ktsv_pkg::REG_AUTH_MODE, 64'(ktsv_pkg::AUTH_STRICT));

    msg.delete();
    send_message(msg, ktsv_pkg::OP_SIGN, EXP_MATCH, 0, 0);
    msg = '{8'h00, 8'hff, 8'h80};
    send_message(msg, ktsv_pkg::OP_SIGN, EXP_MATCH, 1, 0);
    msg = '{8'h01, 8'h02};
    send_message(msg, ktsv_pkg::OP_VERIFY, EXP_MATCH, 1, 0);
    send_message(msg, ktsv_pkg::OP_VERIFY, EXP_FLIP, 0, 0);
    msg = '{8'haa, 8'h55};
    send_message(msg, ktsv_pkg::OP_VERIFY, EXP_MATCH, 0, 100);
    msg.delete();
    send_message(msg, ktsv_pkg::OP_VERIFY, EXP_ZEROS, 0, 0);
    send_message(msg, ktsv_pkg::OP_VERIFY, EXP_ONES, 0, 0);

    drain();
    write_reg(ktsv_pkg::REG_AUTH_MODE, 64'(ktsv_pkg::AUTH_PERMISSIVE));
    msg = '{8'h7f, 8'h80};
    send_message(msg, ktsv_pkg::OP_VERIFY, EXP_MATCH, 1, 0);
    send_message(msg, ktsv_pkg::OP_VERIFY, EXP_FLIP, 1, 0);

    drain();
    write_reg(ktsv_pkg::REG_AUTH_MODE, 64'(ktsv_pkg::AUTH_DISABLED));
    send_message(msg, ktsv_pkg::OP_VERIFY, EXP_FLIP, 1, 0);
    msg = '{8'hff};
    send_message(msg, ktsv_pkg::OP_SIGN, EXP_MATCH, 1, 0);

    drain();
    write_reg(ktsv_pkg::REG_AUTH_MODE, 64'(AUTH_SPARE));
    send_message(msg, ktsv_pkg::OP_VERIFY, EXP_FLIP, 1, 0);
    send_message(msg, ktsv_pkg::OP_VERIFY, EXP_MATCH, 1, 0);

    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: load_key('0);
        1: load_key('1);
        default: load_key(rand_wide());
      endcase
      if (p == 2) write_reg(REG_SPARE, {$urandom, $urandom});
      d = {62'd0, p[1:0]};
      if (p == 6) d = {$urandom, 30'($urandom_range(0, 32'h3fff_ffff)), 2'b00} |
                      64'(p[1:0]);
      write_reg(ktsv_pkg::REG_AUTH_MODE, d);
      calm = (p == 3);
      start = items_sent;
      if (p == 5) begin
        // receiver holds off while short messages keep coming
        calm = 1;
        hold_req++;
        repeat (30) random_message(2);
        calm = 0;
      end
      while (items_sent - start < PHASE_ITEMS) begin
        random_message(80);
        if ($urandom_range(0, 19) == 0) drain();
      end
    end

    drain();
    calm = 0;
    $display("%0d input words, %0d messages, %0d results checked over %0d key settings",
             items_sent, messages, board.checked, settings);
    $display("policies strict, permissive, disabled and the spare value; long result hold-off");
    if (board.errors == 0) $display("keyed_tag_sign_verify test passed");
    else $display("keyed_tag_sign_verify test failed");
    $finish;
  end

endmodule
